/* hw/rtl/prp_pkg.sv */
// shared types and constants for the pcap record parser
`timescale 1ns / 1ps
package prp_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_SHORT_HDR = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  localparam logic [1:0] CL_NOT_IP   = 2'd0;
  localparam logic [1:0] CL_BAD_SUM  = 2'd1;
  localparam logic [1:0] CL_FRAG     = 2'd2;
  localparam logic [1:0] CL_PARSED   = 2'd3;

  localparam logic [31:0] MAGIC_BE = 32'hA1B2C3D4;
  localparam logic [31:0] MAGIC_LE = 32'hD4C3B2A1;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // one event handed from the byte parser to the formatter
  typedef struct packed {
    logic        is_record;
    logic [2:0]  status;
    logic [31:0] seconds;
    logic [31:0] micros;
    logic [31:0] capture;
    logic [15:0] wire_len;
    logic [15:0] ethertype;
    logic [7:0]  vihl;
    logic [15:0] total_len;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [20:0] hsum;
    logic [3:0]  tcp_words;
  } ev_t;

  // one finished result
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] seconds;
    logic [31:0] micros;
    logic [31:0] captured;
    logic [15:0] wire_len;
    logic [1:0]  ip_class;
    logic [7:0]  proto;
    logic [6:0]  transport;
    logic [7:0]  payload;
    logic [16:0] frame_end;
  } res_t;

endpackage

/* hw/rtl/prp_front.sv */
// byte parser: file header, record header and frame fields
`timescale 1ns / 1ps
module prp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output logic          ev_valid,
  output prp_pkg::ev_t  ev
);

  typedef enum logic [1:0] {PH_FILE, PH_RECHDR, PH_DATA} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        be_r, be_nxt;
  logic [31:0] ws_r, ws_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [31:0] mic_r, mic_nxt;
  logic [31:0] cap_r, cap_nxt;
  logic [15:0] wire_r, wire_nxt;
  logic [15:0] eth_r, eth_nxt;
  logic [7:0]  vihl_r, vihl_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [15:0] frag_r, frag_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [20:0] hsum_r, hsum_nxt;
  logic [3:0]  tcpw_r, tcpw_nxt;
  logic        halt_r, halt_nxt;

  logic        small_pos;
  logic [7:0]  p8;
  logic [5:0]  ihl4;
  logic [7:0]  hoff;
  logic [31:0] base;
  logic [32:0] pos_inc;

  assign small_pos = (pos_r[31:8] == 24'd0);
  assign p8        = pos_r[7:0];
  assign pos_inc   = {1'b0, pos_r} + 33'd1;

  // next state and event build
  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; be_nxt = be_r; ws_nxt = ws_r;
    sec_nxt = sec_r; mic_nxt = mic_r; cap_nxt = cap_r; wire_nxt = wire_r;
    eth_nxt = eth_r; vihl_nxt = vihl_r; tlen_nxt = tlen_r; frag_nxt = frag_r;
    proto_nxt = proto_r; hsum_nxt = hsum_r; tcpw_nxt = tcpw_r; halt_nxt = halt_r;
    ev_valid = 1'b0;
    ev = '0;
    base = '0;
    ihl4 = '0;
    hoff = '0;
    if (accept && !halt_r) begin
      case (phase_r)
        PH_FILE: begin
          if (pos_r < 32'd4) ws_nxt = {ws_r[23:0], data_byte};
          if (pos_r == 32'd3) be_nxt = (ws_nxt == prp_pkg::MAGIC_BE);
          if (pos_r == 32'd23) begin
            if (ws_r != prp_pkg::MAGIC_BE && ws_r != prp_pkg::MAGIC_LE) begin
              halt_nxt = 1'b1;
              ev_valid = 1'b1;
              ev.status = prp_pkg::ST_BAD_MAGIC;
            end else begin
              phase_nxt = PH_RECHDR; pos_nxt = '0;
              sec_nxt = '0; mic_nxt = '0; cap_nxt = '0; wire_nxt = '0;
              if (last_byte) halt_nxt = 1'b1;
            end
          end else begin
            pos_nxt = pos_inc[31:0];
            if (last_byte) begin
              halt_nxt = 1'b1;
              ev_valid = 1'b1;
              ev.status = prp_pkg::ST_SHORT_HDR;
            end
          end
        end
        PH_RECHDR: begin
          base = (pos_r[1:0] == 2'd0) ? 32'd0 : ws_r;
          ws_nxt = be_r ? {base[23:0], data_byte} : {data_byte, base[31:8]};
          case (pos_r[3:0])
            4'd3:  sec_nxt = ws_nxt;
            4'd7:  mic_nxt = ws_nxt;
            4'd11: cap_nxt = ws_nxt;
            default: ;
          endcase
          if (pos_r[3:0] == 4'd15) begin
            if (ws_nxt[31:16] != 16'd0) begin
              halt_nxt = 1'b1;
              ev_valid = 1'b1;
              ev.status = prp_pkg::ST_TOO_LARGE;
              ev.seconds = sec_nxt; ev.micros = mic_nxt; ev.capture = cap_nxt;
              ev.wire_len = 16'hffff;
            end else begin
              wire_nxt = ws_nxt[15:0];
              eth_nxt = '0; vihl_nxt = '0; tlen_nxt = '0; frag_nxt = '0;
              proto_nxt = '0; hsum_nxt = '0; tcpw_nxt = '0;
              ev.seconds = sec_nxt; ev.micros = mic_nxt; ev.capture = cap_nxt;
              ev.wire_len = wire_nxt;
              if (cap_r == 32'd0) begin
                ev_valid = 1'b1;
                ev.is_record = 1'b1;
                ev.status = prp_pkg::ST_OK;
                phase_nxt = PH_RECHDR; pos_nxt = '0;
                sec_nxt = '0; mic_nxt = '0; cap_nxt = '0; wire_nxt = '0;
                if (last_byte) halt_nxt = 1'b1;
              end else begin
                phase_nxt = PH_DATA; pos_nxt = '0;
                if (last_byte) begin
                  halt_nxt = 1'b1;
                  ev_valid = 1'b1;
                  ev.status = prp_pkg::ST_TRUNC;
                end
              end
            end
          end else begin
            pos_nxt = pos_inc[31:0];
            if (last_byte) begin
              halt_nxt = 1'b1;
              ev_valid = 1'b1;
              ev.status = prp_pkg::ST_TRUNC;
              ev.seconds = sec_nxt; ev.micros = mic_nxt; ev.capture = cap_nxt;
              ev.wire_len = wire_r;
            end
          end
        end
        PH_DATA: begin
          if (small_pos) begin
            case (p8)
              8'd12: eth_nxt = {data_byte, 8'd0};
              8'd13: eth_nxt = {eth_r[15:8], data_byte};
              8'd14: vihl_nxt = data_byte;
              8'd16: tlen_nxt = {data_byte, 8'd0};
              8'd17: tlen_nxt = {tlen_r[15:8], data_byte};
              8'd20: frag_nxt = {data_byte, 8'd0};
              8'd21: frag_nxt = {frag_r[15:8], data_byte};
              8'd23: proto_nxt = data_byte;
              default: ;
            endcase
          end
          ihl4 = {vihl_nxt[3:0], 2'b00};
          hoff = p8 - 8'd14;
          if (small_pos && p8 >= 8'd14 && hoff < {2'b00, ihl4}) begin
            hsum_nxt = hsum_r + (hoff[0] ? {13'd0, data_byte} : {5'd0, data_byte, 8'd0});
          end
          if (small_pos && p8 == (8'd26 + {2'b00, ihl4})) tcpw_nxt = data_byte[7:4];
          ev.seconds = sec_r; ev.micros = mic_r; ev.capture = cap_r; ev.wire_len = wire_r;
          ev.ethertype = eth_nxt; ev.vihl = vihl_nxt; ev.total_len = tlen_nxt;
          ev.frag = frag_nxt; ev.proto = proto_nxt; ev.hsum = hsum_nxt;
          ev.tcp_words = tcpw_nxt;
          if (pos_inc >= {1'b0, cap_r}) begin
            ev_valid = 1'b1;
            ev.is_record = 1'b1;
            ev.status = prp_pkg::ST_OK;
            phase_nxt = PH_RECHDR; pos_nxt = '0;
            sec_nxt = '0; mic_nxt = '0; cap_nxt = '0; wire_nxt = '0;
            if (last_byte) halt_nxt = 1'b1;
          end else begin
            pos_nxt = pos_inc[31:0];
            if (last_byte) begin
              halt_nxt = 1'b1;
              ev_valid = 1'b1;
              ev.status = prp_pkg::ST_TRUNC;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILE; pos_r <= '0; be_r <= 1'b0; ws_r <= '0;
      sec_r <= '0; mic_r <= '0; cap_r <= '0; wire_r <= '0;
      eth_r <= '0; vihl_r <= '0; tlen_r <= '0; frag_r <= '0;
      proto_r <= '0; hsum_r <= '0; tcpw_r <= '0; halt_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; be_r <= be_nxt; ws_r <= ws_nxt;
      sec_r <= sec_nxt; mic_r <= mic_nxt; cap_r <= cap_nxt; wire_r <= wire_nxt;
      eth_r <= eth_nxt; vihl_r <= vihl_nxt; tlen_r <= tlen_nxt; frag_r <= frag_nxt;
      proto_r <= proto_nxt; hsum_r <= hsum_nxt; tcpw_r <= tcpw_nxt; halt_r <= halt_nxt;
    end
  end

endmodule

/* hw/rtl/prp_fifo.sv */
// short event queue between parser and formatter
`timescale 1ns / 1ps
module prp_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  prp_pkg::ev_t  wdata,
  input  logic          rd,
  output prp_pkg::ev_t  rdata,
  output logic          full,
  output logic          not_empty
);

  prp_pkg::ev_t             mem [prp_pkg::QDEPTH];
  logic [prp_pkg::QAW-1:0]  wp_r, rp_r;
  logic [prp_pkg::QAW:0]    count_r;

  assign full      = (count_r == (prp_pkg::QAW+1)'(prp_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; count_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      if (wr && !rd) count_r <= count_r + 1'b1;
      else if (rd && !wr) count_r <= count_r - 1'b1;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (prp_pkg::QAW+1)'(prp_pkg::QDEPTH)) else $error("queue overfilled");
  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    rd |-> count_r != '0) else $error("read from empty queue");
  a_wr_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> count_r == $past(count_r) + 1'b1) else $error("count did not grow");

endmodule

/* hw/rtl/prp_back.sv */
// result formatter with output register
`timescale 1ns / 1ps
module prp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ev_avail,
  input  prp_pkg::ev_t  ev,
  output logic          ev_take,
  input  logic          pop,
  output logic          out_valid,
  output prp_pkg::res_t res
);

  logic          valid_r;
  prp_pkg::res_t res_r, res_nxt;
  logic [16:0]   fold;
  logic [16:0]   cap_end;
  logic          ipv4;
  logic [6:0]    tr;

  assign ev_take   = ev_avail && (!valid_r || pop);
  assign out_valid = valid_r;
  assign res       = res_r;

  // classify one event
  always_comb begin
    fold    = {1'b0, 11'd0, ev.hsum[20:16]} + {1'b0, ev.hsum[15:0]};
    cap_end = (ev.capture[31:17] != 15'd0) ? 17'h1ffff : ev.capture[16:0];
    ipv4    = (ev.capture > 32'd34) && (ev.ethertype == prp_pkg::ETH_IPV4) &&
              (ev.vihl[7:4] == 4'h4);
    tr      = 7'd14 + {1'b0, ev.vihl[3:0], 2'b00};
    res_nxt = '0;
    res_nxt.status   = ev.status;
    res_nxt.seconds  = ev.seconds;
    res_nxt.micros   = ev.micros;
    res_nxt.captured = ev.capture;
    res_nxt.wire_len = ev.wire_len;
    if (ev.is_record) begin
      res_nxt.frame_end = cap_end;
      if (ipv4) begin
        res_nxt.proto = ev.proto;
        if (fold != 17'h0ffff) begin
          res_nxt.ip_class = prp_pkg::CL_BAD_SUM;
        end else if (ev.frag[13:0] != 14'd0) begin
          res_nxt.ip_class = prp_pkg::CL_FRAG;
        end else begin
          res_nxt.ip_class  = prp_pkg::CL_PARSED;
          res_nxt.frame_end = 17'd14 + {1'b0, ev.total_len};
          if (ev.proto == prp_pkg::PROTO_TCP) begin
            res_nxt.transport = tr;
            res_nxt.payload   = {1'b0, tr} + {2'b00, ev.tcp_words, 2'b00};
          end else if (ev.proto == prp_pkg::PROTO_UDP) begin
            res_nxt.transport = tr;
            res_nxt.payload   = {1'b0, tr} + 8'd8;
          end else if (ev.proto == prp_pkg::PROTO_ICMP) begin
            res_nxt.transport = tr;
          end
        end
      end else begin
        res_nxt.ip_class = prp_pkg::CL_NOT_IP;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ev_take) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_take) res_r <= res_nxt;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !pop) |=> valid_r && res_r == $past(res_r)) else $error("result lost");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    ev_take |=> valid_r) else $error("loaded result not shown");
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && valid_r && !ev_avail) |=> !valid_r) else $error("popped result repeated");

endmodule

/* hw/rtl/pcap_ipv4_record_parser.sv */
// top level of the pcap record and IPv4 header parser
//
// Usage: feed the capture file one byte per item on in_data_byte, with
// in_last_byte set on the final byte. An item is taken on a clock edge with
// push high and full low. Results come out as a queue: while empty is low
// the oldest result sits on the out_ ports and pop takes it.
// One result is produced per record or per error; after an error or the end
// of the file the block ignores further bytes until reset.
// Throughput: one byte per cycle while full is low; the parser updates its
// counters and the running header sum for every accepted byte.
// Path: the parser writes the event that completes a result into the event
// queue, and the formatter then loads it into the output register.
// Stalls: when pop stays low, events collect in a four-entry queue behind the
// output register; full rises only when queue and output are both occupied.
// Reset: synchronous, active low rst_n; clears the parser back to the file
// header phase and empties the queue and the output register.
`timescale 1ns / 1ps
module pcap_ipv4_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [31:0] out_stamp_seconds,
  output logic [31:0] out_stamp_micros,
  output logic [31:0] out_captured_bytes,
  output logic [15:0] out_wire_bytes,
  output logic [1:0]  out_ip_class,
  output logic [7:0]  out_proto_number,
  output logic [6:0]  out_transport_start,
  output logic [7:0]  out_payload_start,
  output logic [16:0] out_frame_end
);

  logic          ev_valid, q_full, q_ne, ev_take, out_valid;
  prp_pkg::ev_t  ev_in, ev_out;
  prp_pkg::res_t res;

  assign full  = q_full;
  assign empty = !out_valid;

  prp_front u_front (
    .clk(clk), .rst_n(rst_n), .accept(push && !q_full),
    .data_byte(in_data_byte), .last_byte(in_last_byte),
    .ev_valid(ev_valid), .ev(ev_in)
  );

  prp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr(ev_valid), .wdata(ev_in),
    .rd(ev_take), .rdata(ev_out), .full(q_full), .not_empty(q_ne)
  );

  prp_back u_back (
    .clk(clk), .rst_n(rst_n), .ev_avail(q_ne), .ev(ev_out), .ev_take(ev_take),
    .pop(pop && out_valid), .out_valid(out_valid), .res(res)
  );

  assign out_status          = res.status;
  assign out_stamp_seconds   = res.seconds;
  assign out_stamp_micros    = res.micros;
  assign out_captured_bytes  = res.captured;
  assign out_wire_bytes      = res.wire_len;
  assign out_ip_class        = res.ip_class;
  assign out_proto_number    = res.proto;
  assign out_transport_start = res.transport;
  assign out_payload_start   = res.payload;
  assign out_frame_end       = res.frame_end;

endmodule
